// ===== rtl/atc_pkg.sv =====
// Shared constants, types and tables of the accelerometer tilt block.
package atc_pkg;

    localparam int CALIB_SAMPLES = 200;
    localparam int CORDIC_ITERS  = 16;
    localparam int ITERS = (CORDIC_ITERS < 24) ? CORDIC_ITERS : 24;
    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

    localparam int DIV_SH  = 24 + $clog2(CALIB_SAMPLES);
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((longint'(1) << DIV_SH) + longint'(CALIB_SAMPLES) - longint'(1))
                 / longint'(CALIB_SAMPLES));

    localparam int XY_W  = 37;
    localparam int ANG_W = 26;

    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] ROLL_LIM = 26'sd23040;
    localparam logic signed [ANG_W-1:0] PITCH_LIM = 26'sd11520;

    localparam logic [7:0] CFG_SCALE = 8'd0;
    localparam logic [7:0] CFG_ALPHA = 8'd1;

    typedef logic signed [ANG_W-1:0] t_angle;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_MUL,
        ST_SC_USE,
        ST_CAL_ADD,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_STORE,
        ST_FLT_SUB,
        ST_FLT_MUL,
        ST_FLT_USE,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_ROLL_GO,
        ST_ROLL_WAIT,
        ST_PITCH_GO,
        ST_PITCH_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   busy;
        logic   done;
        t_angle angle;
    } t_cordic_stat;

    function automatic t_angle atan_entry(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:  v = 26'sd1474560;
            5'd1:  v = 26'sd870484;
            5'd2:  v = 26'sd459940;
            5'd3:  v = 26'sd233473;
            5'd4:  v = 26'sd117189;
            5'd5:  v = 26'sd58652;
            5'd6:  v = 26'sd29333;
            5'd7:  v = 26'sd14667;
            5'd8:  v = 26'sd7334;
            5'd9:  v = 26'sd3667;
            5'd10: v = 26'sd1833;
            5'd11: v = 26'sd917;
            5'd12: v = 26'sd458;
            5'd13: v = 26'sd229;
            5'd14: v = 26'sd115;
            5'd15: v = 26'sd57;
            5'd16: v = 26'sd29;
            5'd17: v = 26'sd14;
            5'd18: v = 26'sd7;
            5'd19: v = 26'sd4;
            5'd20: v = 26'sd2;
            5'd21: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/atc_cordic.sv =====
// Iterative vectoring CORDIC that gives atan2(y, x) in 1/32768 degree.
module atc_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [17:0]   i_y,
    input  logic signed [17:0]   i_x,
    output atc_pkg::t_cordic_stat o_stat
);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_zero;
    logic [4:0]                         r_i;
    logic signed [atc_pkg::XY_W-1:0]    r_x;
    logic signed [atc_pkg::XY_W-1:0]    r_y;
    atc_pkg::t_angle                    r_acc;

    logic signed [17:0]                 x0;
    logic signed [17:0]                 y0;
    logic signed [atc_pkg::XY_W-1:0]    dx;
    logic signed [atc_pkg::XY_W-1:0]    dy;

    always_comb begin
        x0 = (i_x < 0) ? -i_x : i_x;
        y0 = (i_x < 0) ? -i_y : i_y;
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == 5'(atc_pkg::ITERS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == 0) && (i_y == 0);
                r_x    <= atc_pkg::XY_W'(x0) <<< 16;
                r_y    <= atc_pkg::XY_W'(y0) <<< 16;
                if (i_x < 0) begin
                    r_acc <= (i_y >= 0) ? atc_pkg::DEG180 : -atc_pkg::DEG180;
                end else begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x   <= r_x + dx;
                    r_y   <= r_y - dy;
                    r_acc <= r_acc + atc_pkg::atan_entry(r_i);
                end else begin
                    r_x   <= r_x - dx;
                    r_y   <= r_y + dy;
                    r_acc <= r_acc - atc_pkg::atan_entry(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(atc_pkg::ITERS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_stat.angle = r_zero ? '0 : r_acc;

endmodule

// ===== rtl/atc_isqrt.sv =====
// Iterative digit-by-digit integer square root of a 32-bit value giving a 16-bit root.
module atc_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_busy,
    output logic [15:0] o_root
);

    logic        r_busy;
    logic [31:0] r_n;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic [31:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_n    <= i_value;
            r_res  <= '0;
            r_bit  <= 32'h4000_0000;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit == 32'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[15:0];

endmodule

// ===== rtl/accel_tilt_with_calibration_top.sv =====
// Accelerometer tilt block: calibration, low-pass filter, roll and pitch.
// A calibration sample is scaled and added to the sums; the last one also adds three
// offset divisions done by reciprocal multiplication. A running sample is filtered,
// then takes two passes of the shared 16-iteration CORDIC unit; a stalled output holds
// the block until the transfer, and a new sample is accepted only in idle.
// Synchronous active-low reset clears calibration, offsets, filter and state.
module accel_tilt_with_calibration_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // raw_x [9:0], raw_y [19:10], raw_z [29:20], zeros [31:30]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], roll [63:48],
    // pitch [78:64], zero [79]
    output logic [79:0] o_m_axis_tdata,
    // status [0]
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int N = atc_pkg::CALIB_SAMPLES;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end else if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        if (v > 25'sd8388607) begin
            return 24'sh7fffff;
        end else if (v < -25'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] ang_out(input atc_pkg::t_angle a,
                                                   input atc_pkg::t_angle lim);
        atc_pkg::t_angle v;
        v = (a + 26'sd128) >>> 8;
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v[15:0];
    endfunction

    atc_pkg::t_state r_state, n_state;

    logic [15:0]                    r_scale, r_alpha;
    logic [atc_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [1:0]                     r_k, n_k;
    logic signed [9:0]              r_raw [3];
    logic signed [15:0]             r_s [3], n_s [3];
    logic signed [23:0]             r_sum [3], n_sum [3];
    logic signed [15:0]             r_off [3], n_off [3];
    logic signed [15:0]             r_filt [3], n_filt [3];
    logic signed [34:0]             r_prod;
    logic signed [16:0]             r_diff, n_diff;
    logic [31:0]                    r_sq, n_sq;
    logic [23:0]                    r_div_d, n_div_d;
    logic                           r_div_neg, n_div_neg;
    logic signed [15:0]             r_roll, n_roll;
    logic signed [14:0]             r_pitch, n_pitch;
    logic                           r_run, n_run;
    logic                           r_out_valid;
    logic                           r_out_status;
    logic [79:0]                    r_out_data;

    logic signed [17:0]             mul_a;
    logic signed [16:0]             mul_b;
    logic signed [34:0]             mul_p;

    logic                           cordic_start;
    logic signed [17:0]             cordic_y, cordic_x;
    atc_pkg::t_cordic_stat          cordic_stat;
    logic                           sqrt_start;
    logic                           sqrt_busy;
    logic [15:0]                    sqrt_root;

    logic                           accept;
    logic                           load_out;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign load_out = (r_state == atc_pkg::ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // Shared multiplier with a registered product.
    always_comb begin
        case (r_state)
            atc_pkg::ST_SC_MUL: begin
                mul_a = 18'(r_raw[r_k]);
                mul_b = $signed({1'b0, r_scale});
            end
            atc_pkg::ST_FLT_MUL: begin
                mul_a = 18'(r_diff);
                mul_b = $signed({1'b0, r_alpha});
            end
            atc_pkg::ST_SQ_Y: begin
                mul_a = 18'(r_filt[1]);
                mul_b = 17'(r_filt[1]);
            end
            atc_pkg::ST_SQ_Z: begin
                mul_a = 18'(r_filt[2]);
                mul_b = 17'(r_filt[2]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            atc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = atc_pkg::ST_SC_MUL;
                end
            end
            atc_pkg::ST_SC_MUL: n_state = atc_pkg::ST_SC_USE;
            atc_pkg::ST_SC_USE: begin
                if (r_k != 2'd2) begin
                    n_state = atc_pkg::ST_SC_MUL;
                end else if (r_cnt < atc_pkg::CNT_W'(N)) begin
                    n_state = atc_pkg::ST_CAL_ADD;
                end else begin
                    n_state = atc_pkg::ST_FLT_SUB;
                end
            end
            atc_pkg::ST_CAL_ADD: begin
                if (r_cnt + 1'b1 == atc_pkg::CNT_W'(N)) begin
                    n_state = atc_pkg::ST_DIV_LOAD;
                end else begin
                    n_state = atc_pkg::ST_DONE;
                end
            end
            atc_pkg::ST_DIV_LOAD: n_state = atc_pkg::ST_DIV_STEP;
            atc_pkg::ST_DIV_STEP: n_state = atc_pkg::ST_DIV_STORE;
            atc_pkg::ST_DIV_STORE: begin
                n_state = (r_k == 2'd2) ? atc_pkg::ST_DONE : atc_pkg::ST_DIV_LOAD;
            end
            atc_pkg::ST_FLT_SUB: n_state = atc_pkg::ST_FLT_MUL;
            atc_pkg::ST_FLT_MUL: n_state = atc_pkg::ST_FLT_USE;
            atc_pkg::ST_FLT_USE: begin
                n_state = (r_k == 2'd2) ? atc_pkg::ST_SQ_Y : atc_pkg::ST_FLT_SUB;
            end
            atc_pkg::ST_SQ_Y:    n_state = atc_pkg::ST_SQ_Z;
            atc_pkg::ST_SQ_Z:    n_state = atc_pkg::ST_SQ_SUM;
            atc_pkg::ST_SQ_SUM:  n_state = atc_pkg::ST_ROLL_GO;
            atc_pkg::ST_ROLL_GO: n_state = atc_pkg::ST_ROLL_WAIT;
            atc_pkg::ST_ROLL_WAIT: begin
                if (cordic_stat.done) begin
                    n_state = atc_pkg::ST_PITCH_GO;
                end
            end
            atc_pkg::ST_PITCH_GO: begin
                if (!sqrt_busy) begin
                    n_state = atc_pkg::ST_PITCH_WAIT;
                end
            end
            atc_pkg::ST_PITCH_WAIT: begin
                if (cordic_stat.done) begin
                    n_state = atc_pkg::ST_DONE;
                end
            end
            atc_pkg::ST_DONE: begin
                if (load_out) begin
                    n_state = atc_pkg::ST_IDLE;
                end
            end
            default: n_state = atc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit control.
    always_comb begin
        logic signed [15:0] corr;
        logic signed [35:0] facc;
        logic [23:0]        mag;
        logic [48:0]        div_prod;
        logic signed [25:0] m;

        n_cnt     = r_cnt;
        n_k       = r_k;
        n_s       = r_s;
        n_sum     = r_sum;
        n_off     = r_off;
        n_filt    = r_filt;
        n_diff    = r_diff;
        n_sq      = r_sq;
        n_div_d   = r_div_d;
        n_div_neg = r_div_neg;
        n_roll    = r_roll;
        n_pitch   = r_pitch;
        n_run     = r_run;
        cordic_start = 1'b0;
        cordic_y     = '0;
        cordic_x     = '0;
        sqrt_start   = 1'b0;
        corr     = '0;
        facc     = '0;
        mag      = '0;
        div_prod = '0;
        m        = '0;

        case (r_state)
            atc_pkg::ST_IDLE: begin
                n_k = '0;
            end
            atc_pkg::ST_SC_USE: begin
                n_s[r_k] = sat16(48'((r_prod + 35'sd8) >>> 4));
                n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                n_run    = (r_cnt >= atc_pkg::CNT_W'(N));
            end
            atc_pkg::ST_CAL_ADD: begin
                for (int j = 0; j < 3; j++) begin
                    n_sum[j] = sat24(25'(r_sum[j]) + 25'(r_s[j]));
                end
                n_cnt = r_cnt + 1'b1;
                n_k   = '0;
            end
            atc_pkg::ST_DIV_LOAD: begin
                n_div_neg = r_sum[r_k] < 0;
                mag       = n_div_neg ? 24'(-r_sum[r_k]) : 24'(r_sum[r_k]);
                n_div_d   = mag + 24'(N / 2);
            end
            atc_pkg::ST_DIV_STEP: begin
                div_prod = 49'(r_div_d) * 49'(atc_pkg::DIV_RECIP);
                n_div_d  = 24'(div_prod >> atc_pkg::DIV_SH);
            end
            atc_pkg::ST_DIV_STORE: begin
                m = $signed({2'b00, r_div_d});
                if (r_div_neg) begin
                    m = -m;
                end
                if (r_k == 2'd2) begin
                    m = m - 26'sd4096;
                end
                n_off[r_k] = sat16(48'(m));
                n_k        = r_k + 2'd1;
            end
            atc_pkg::ST_FLT_SUB: begin
                corr   = sat16(48'(17'(r_s[r_k]) - 17'(r_off[r_k])));
                n_diff = 17'(corr) - 17'(r_filt[r_k]);
            end
            atc_pkg::ST_FLT_USE: begin
                facc = (36'(r_filt[r_k]) <<< 16) + 36'(r_prod);
                n_filt[r_k] = sat16(48'((facc + 36'sd32768) >>> 16));
                n_k = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            atc_pkg::ST_SQ_Z: begin
                n_sq = r_prod[31:0];
            end
            atc_pkg::ST_SQ_SUM: begin
                n_sq = r_sq + r_prod[31:0];
            end
            atc_pkg::ST_ROLL_GO: begin
                cordic_start = 1'b1;
                cordic_y     = 18'(r_filt[1]);
                cordic_x     = 18'(r_filt[2]);
                sqrt_start   = 1'b1;
            end
            atc_pkg::ST_ROLL_WAIT: begin
                if (cordic_stat.done) begin
                    n_roll = ang_out(cordic_stat.angle, atc_pkg::ROLL_LIM);
                end
            end
            atc_pkg::ST_PITCH_GO: begin
                cordic_start = !sqrt_busy;
                cordic_y     = -18'(r_filt[0]);
                cordic_x     = $signed({2'b00, sqrt_root});
            end
            atc_pkg::ST_PITCH_WAIT: begin
                if (cordic_stat.done) begin
                    n_pitch = 15'(ang_out(cordic_stat.angle, atc_pkg::PITCH_LIM));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atc_pkg::ST_IDLE;
            r_scale     <= 16'd256;
            r_alpha     <= 16'd13107;
            r_cnt       <= '0;
            r_k         <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                r_sum[j]  <= '0;
                r_off[j]  <= '0;
                r_filt[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_run   <= n_run;
            r_sum   <= n_sum;
            r_off   <= n_off;
            r_filt  <= n_filt;
            if (i_cfg_valid) begin
                if (i_cfg_index == atc_pkg::CFG_SCALE) begin
                    r_scale <= i_cfg_data;
                end else if (i_cfg_index == atc_pkg::CFG_ALPHA) begin
                    r_alpha <= i_cfg_data;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= mul_p;
        r_s       <= n_s;
        r_diff    <= n_diff;
        r_sq      <= n_sq;
        r_div_d   <= n_div_d;
        r_div_neg <= n_div_neg;
        r_roll    <= n_roll;
        r_pitch   <= n_pitch;
        if (accept) begin
            r_raw[0] <= i_s_axis_tdata[9:0];
            r_raw[1] <= i_s_axis_tdata[19:10];
            r_raw[2] <= i_s_axis_tdata[29:20];
        end
        if (load_out) begin
            r_out_status <= r_run;
            if (r_run) begin
                r_out_data <= {1'b0, r_pitch, r_roll, r_filt[2], r_filt[1], r_filt[0]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    atc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_y     (cordic_y),
        .i_x     (cordic_x),
        .o_stat  (cordic_stat)
    );

    atc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_sq),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    assign o_s_axis_tready = (r_state == atc_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;
    assign o_cfg_ready     = 1'b1;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= atc_pkg::CNT_W'(N))
        else $error("calibration count exceeds its limit");

    a_cal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_status |-> r_out_data == '0)
        else $error("calibrating result carries nonzero data");

    a_run_after_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |-> r_cnt == atc_pkg::CNT_W'(N))
        else $error("running result before calibration finished");

    a_cordic_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_start |-> !cordic_stat.busy)
        else $error("CORDIC started while busy");

    a_pitch_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_start && r_state == atc_pkg::ST_PITCH_GO |-> !sqrt_busy)
        else $error("pitch pass started before the root was ready");

endmodule
